>>> hdl/rbls_pkg.sv
// Shared types, codes and helper functions of the ranked box list unit.
// Used by the slot evaluator and by the top level; depends on nothing else.
`default_nettype none

package rbls_pkg;

  // Default list depth.
  localparam int unsigned SLOTS_DEF = 8;

  // Field widths fixed by the interface.
  localparam int unsigned POS_W       = 10;
  localparam int unsigned SIDE_W      = 10;
  localparam int unsigned ORIENT_W    = 3;
  localparam int unsigned SCORE_W     = 32;
  localparam int unsigned VOX_W       = 24;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;

  // Request kinds carried in the input tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_OFFER = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_BELOW        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_BETTER   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLAP_KEPT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE         = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_SIDE_A     = 2'd0;
  localparam logic [1:0] REG_SIDE_B     = 2'd1;
  localparam logic [1:0] REG_SIDE_C     = 2'd2;
  localparam logic [1:0] REG_MIN_VOXELS = 2'd3;

  // Orientation modes: side lengths along x, y, z.
  localparam logic [ORIENT_W-1:0] ORI_ABC = 3'd0;
  localparam logic [ORIENT_W-1:0] ORI_ACB = 3'd1;
  localparam logic [ORIENT_W-1:0] ORI_BAC = 3'd2;
  localparam logic [ORIENT_W-1:0] ORI_BCA = 3'd3;
  localparam logic [ORIENT_W-1:0] ORI_CAB = 3'd4;
  localparam logic [ORIENT_W-1:0] ORI_CBA = 3'd5;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_EV,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_RD_RD,
    S_RD_EV,
    S_RESP
  } state_e;

  // Configured side lengths.
  typedef struct packed {
    logic [SIDE_W-1:0] a;
    logic [SIDE_W-1:0] b;
    logic [SIDE_W-1:0] c;
  } side_cfg_t;

  // Side lengths along the three axes.
  typedef struct packed {
    logic [SIDE_W-1:0] sx;
    logic [SIDE_W-1:0] sy;
    logic [SIDE_W-1:0] sz;
  } sides_t;

  // One list entry without its orientation.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   z;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   x;
  } entry_t;

  // Candidate box held during an offer.
  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [ORIENT_W-1:0] orient;
    logic [POS_W-1:0]    z;
    logic [POS_W-1:0]    y;
    logic [POS_W-1:0]    x;
  } cand_t;

  // Result word payload, packed with the slot in the lowest bits.
  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [ORIENT_W-1:0] orient;
    logic [POS_W-1:0]    z;
    logic [POS_W-1:0]    y;
    logic [POS_W-1:0]    x;
    logic [IDX_W-1:0]    slot;
  } result_t;

  // Outcome of comparing the candidate against one slot.
  typedef struct packed {
    logic beats;
    logic touches;
  } eval_t;

  // Side lengths for an orientation mode; modes six and seven give zero sides.
  function automatic sides_t sides_of(input logic [ORIENT_W-1:0] mode,
                                      input side_cfg_t cfg);
    sides_t s;
    case (mode)
      ORI_ABC: s = '{sx: cfg.a, sy: cfg.b, sz: cfg.c};
      ORI_ACB: s = '{sx: cfg.a, sy: cfg.c, sz: cfg.b};
      ORI_BAC: s = '{sx: cfg.b, sy: cfg.a, sz: cfg.c};
      ORI_BCA: s = '{sx: cfg.b, sy: cfg.c, sz: cfg.a};
      ORI_CAB: s = '{sx: cfg.c, sy: cfg.a, sz: cfg.b};
      ORI_CBA: s = '{sx: cfg.c, sy: cfg.b, sz: cfg.a};
      default: s = '0;
    endcase
    return s;
  endfunction

  // True when two intervals on one axis overlap or touch.
  function automatic logic axis_touch(input logic [POS_W-1:0]  stored,
                                      input logic [POS_W-1:0]  cand,
                                      input logic [SIDE_W-1:0] stored_len,
                                      input logic [SIDE_W-1:0] cand_len);
    logic res;
    if (stored < cand) begin
      res = (cand - stored) <= stored_len;
    end else begin
      res = (stored - cand) <= cand_len;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rbls_box_eval.sv
// Shared slot evaluator: score compare and box overlap test for one slot.
// Depends on rbls_pkg for the entry types and the geometry helpers.
`default_nettype none

module rbls_box_eval (
  input  rbls_pkg::side_cfg_t             cfg_i,
  input  rbls_pkg::cand_t                 cand_i,
  input  rbls_pkg::entry_t                entry_i,
  input  logic [rbls_pkg::ORIENT_W-1:0]   entry_orient_i,
  output rbls_pkg::eval_t                 eval_o
);

  rbls_pkg::sides_t cand_sides;
  rbls_pkg::sides_t entry_sides;

  // Side lengths of both boxes from their orientation modes.
  assign cand_sides  = rbls_pkg::sides_of(cand_i.orient, cfg_i);
  assign entry_sides = rbls_pkg::sides_of(entry_orient_i, cfg_i);

  // The candidate beats the slot on a strictly larger score; boxes that
  // touch on every axis count as overlapping.
  always_comb begin
    eval_o.beats   = cand_i.score > entry_i.score;
    eval_o.touches =
      rbls_pkg::axis_touch(entry_i.x, cand_i.x, entry_sides.sx, cand_sides.sx) &&
      rbls_pkg::axis_touch(entry_i.y, cand_i.y, entry_sides.sy, cand_sides.sy) &&
      rbls_pkg::axis_touch(entry_i.z, cand_i.z, entry_sides.sz, cand_sides.sz);
  end

endmodule

`default_nettype wire

>>> hdl/ranked_box_list_overlap_suppress_unit.sv
// Top level of the ranked box list unit: sequencer, list memory, APB registers.
// Depends on rbls_pkg and instantiates rbls_box_eval.
//
// The unit keeps a score-ordered list of SLOTS boxes in a memory with one read
// and one write port, and handles one request word at a time. An offer scans
// the list with one memory read and one pass through the shared slot evaluator
// per slot; a kept offer then shifts entries down one at a time and writes the
// candidate in. An offer below the voxel threshold, a clear or an unused kind
// goes straight to the result, and a slot read does one memory read first. A
// finished result sits in an output register, so the next request is taken
// while the previous result waits. Clearing the list is done at once through
// per-slot valid bits; no clearing pass follows reset.
`default_nettype none

module ranked_box_list_overlap_suppress_unit #(
  parameter int unsigned SLOTS = rbls_pkg::SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request stream. tdata from bit 0: pos_x, pos_y, pos_z, orient, score,
  // voxel_count, slot_index, zero fill. tuser: kind.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rbls_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [rbls_pkg::KIND_W-1:0]         s_axis_tuser,
  // Result stream. tdata from bit 0: slot, entry_x, entry_y, entry_z,
  // entry_orient, entry_score, zero fill. tuser: status.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rbls_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic [rbls_pkg::STATUS_W-1:0]       m_axis_tuser,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rbls_pkg::ADDR_W-1:0]         paddr,
  input  logic [rbls_pkg::DATA_W-1:0]         pwdata,
  output logic [rbls_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IW   = rbls_pkg::IDX_W;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [rbls_pkg::SIDE_W-1:0] side_a_q, side_b_q, side_c_q;
  logic [rbls_pkg::VOX_W-1:0]  min_voxels_q;
  logic                        cfg_wr;
  rbls_pkg::side_cfg_t         side_cfg;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign side_cfg = '{a: side_a_q, b: side_b_q, c: side_c_q};

  // Register writes on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_a_q     <= rbls_pkg::SIDE_W'(1);
      side_b_q     <= rbls_pkg::SIDE_W'(1);
      side_c_q     <= rbls_pkg::SIDE_W'(1);
      min_voxels_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rbls_pkg::REG_SIDE_A:     side_a_q     <= pwdata[rbls_pkg::SIDE_W-1:0];
        rbls_pkg::REG_SIDE_B:     side_b_q     <= pwdata[rbls_pkg::SIDE_W-1:0];
        rbls_pkg::REG_SIDE_C:     side_c_q     <= pwdata[rbls_pkg::SIDE_W-1:0];
        rbls_pkg::REG_MIN_VOXELS: min_voxels_q <= pwdata[rbls_pkg::VOX_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      rbls_pkg::REG_SIDE_A:     prdata = rbls_pkg::DATA_W'(side_a_q);
      rbls_pkg::REG_SIDE_B:     prdata = rbls_pkg::DATA_W'(side_b_q);
      rbls_pkg::REG_SIDE_C:     prdata = rbls_pkg::DATA_W'(side_c_q);
      rbls_pkg::REG_MIN_VOXELS: prdata = rbls_pkg::DATA_W'(min_voxels_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request word fields
  // ---------------------------------------------------------------------
  rbls_pkg::kind_e             in_kind;
  rbls_pkg::cand_t             in_cand;
  logic [rbls_pkg::VOX_W-1:0]  in_vox;
  logic [IW-1:0]               in_slot_idx;
  logic                        in_range;
  logic                        in_acc;

  assign in_kind       = rbls_pkg::kind_e'(s_axis_tuser);
  assign in_cand.x      = s_axis_tdata[9:0];
  assign in_cand.y      = s_axis_tdata[19:10];
  assign in_cand.z      = s_axis_tdata[29:20];
  assign in_cand.orient = s_axis_tdata[32:30];
  assign in_cand.score  = s_axis_tdata[64:33];
  assign in_vox         = s_axis_tdata[88:65];
  assign in_slot_idx    = s_axis_tdata[91:89];
  assign in_range       = 32'(in_slot_idx) < SLOTS;
  assign in_acc         = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------
  rbls_pkg::state_e state_q, state_d;
  logic [AW-1:0]    k_q;
  logic             beat_found_q, beat_found_d;
  logic [AW-1:0]    beat_q, beat_d;
  logic             ov_found_q, ov_found_d;
  logic [AW-1:0]    ov_q, ov_d;
  rbls_pkg::cand_t  cand_q;
  logic [IW-1:0]    si_q;

  // List memory and its valid bits; orientations survive a clear.
  rbls_pkg::entry_t                data_mem   [SLOTS];
  logic [rbls_pkg::ORIENT_W-1:0]   orient_mem [SLOTS];
  logic [SLOTS-1:0]                dvld_q;
  logic [SLOTS-1:0]                ovld_q;
  rbls_pkg::entry_t                rd_data_q;
  logic [rbls_pkg::ORIENT_W-1:0]   rd_orient_q;
  logic                            rd_dvld_q, rd_ovld_q;
  rbls_pkg::entry_t                ent_data;
  logic [rbls_pkg::ORIENT_W-1:0]   ent_orient;

  // Memory port control.
  logic [AW-1:0]                   rd_addr;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  rbls_pkg::entry_t                wr_data;
  logic [rbls_pkg::ORIENT_W-1:0]   wr_orient;
  logic                            list_clear;

  // Result holding and output registers.
  logic [rbls_pkg::STATUS_W-1:0]   res_status_q;
  rbls_pkg::result_t               res_q;
  logic [rbls_pkg::STATUS_W-1:0]   out_status_q;
  rbls_pkg::result_t               out_q;
  logic                            out_vld_q;
  logic                            out_free;

  rbls_pkg::eval_t                 ev;

  // Slots never written read as zero; cleared slots read zero corners and scores.
  assign ent_data   = rd_dvld_q ? rd_data_q : '0;
  assign ent_orient = rd_ovld_q ? rd_orient_q : '0;

  // One evaluator serves every slot in turn.
  rbls_box_eval u_eval (
    .cfg_i          (side_cfg),
    .cand_i         (cand_q),
    .entry_i        (ent_data),
    .entry_orient_i (ent_orient),
    .eval_o         (ev)
  );

  // Scan bookkeeping: first beaten slot and first overlapping slot before the last.
  always_comb begin
    beat_found_d = beat_found_q;
    beat_d       = beat_q;
    ov_found_d   = ov_found_q;
    ov_d         = ov_q;
    if (state_q == rbls_pkg::S_SC_EV) begin
      if (!beat_found_q && ev.beats) begin
        beat_found_d = 1'b1;
        beat_d       = k_q;
      end
      if (!ov_found_q && ev.touches && (k_q != LAST)) begin
        ov_found_d = 1'b1;
        ov_d       = k_q;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbls_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_kind)
            rbls_pkg::KIND_OFFER:
              state_d = (in_vox <= min_voxels_q) ? rbls_pkg::S_RESP : rbls_pkg::S_SC_RD;
            rbls_pkg::KIND_READ:
              state_d = in_range ? rbls_pkg::S_RD_RD : rbls_pkg::S_RESP;
            default:
              state_d = rbls_pkg::S_RESP;
          endcase
        end
      end
      rbls_pkg::S_SC_RD: state_d = rbls_pkg::S_SC_EV;
      rbls_pkg::S_SC_EV: begin
        if (k_q != LAST) begin
          state_d = rbls_pkg::S_SC_RD;
        end else if (!beat_found_d || (ov_d < beat_d)) begin
          state_d = rbls_pkg::S_RESP;
        end else if (ov_d > beat_d) begin
          state_d = rbls_pkg::S_SH_RD;
        end else begin
          state_d = rbls_pkg::S_INS;
        end
      end
      rbls_pkg::S_SH_RD: state_d = rbls_pkg::S_SH_WR;
      rbls_pkg::S_SH_WR:
        state_d = (AW'(k_q - 1'b1) == beat_q) ? rbls_pkg::S_INS : rbls_pkg::S_SH_RD;
      rbls_pkg::S_INS:   state_d = rbls_pkg::S_RESP;
      rbls_pkg::S_RD_RD: state_d = rbls_pkg::S_RD_EV;
      rbls_pkg::S_RD_EV: state_d = rbls_pkg::S_RESP;
      rbls_pkg::S_RESP:  if (out_free) state_d = rbls_pkg::S_IDLE;
      default:           state_d = rbls_pkg::S_IDLE;
    endcase
  end

  // Handshake and memory port control.
  always_comb begin
    s_axis_tready = (state_q == rbls_pkg::S_IDLE);
    out_free      = !out_vld_q || m_axis_tready;
    list_clear    = in_acc && (in_kind == rbls_pkg::KIND_CLEAR);
    rd_addr       = k_q;
    wr_en         = 1'b0;
    wr_addr       = k_q;
    wr_data       = ent_data;
    wr_orient     = ent_orient;
    case (state_q)
      rbls_pkg::S_SH_RD: rd_addr = AW'(k_q - 1'b1);
      rbls_pkg::S_RD_RD: rd_addr = AW'(si_q);
      rbls_pkg::S_SH_WR: wr_en = 1'b1;
      rbls_pkg::S_INS: begin
        wr_en     = 1'b1;
        wr_addr   = beat_q;
        wr_data   = '{score: cand_q.score, z: cand_q.z, y: cand_q.y, x: cand_q.x};
        wr_orient = cand_q.orient;
      end
      default: ;
    endcase
  end

  // List memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      data_mem[wr_addr]   <= wr_data;
      orient_mem[wr_addr] <= wr_orient;
    end
    rd_data_q   <= data_mem[rd_addr];
    rd_orient_q <= orient_mem[rd_addr];
  end

  // Valid bits: reset empties everything, a clear empties corners and scores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q    <= '0;
      ovld_q    <= '0;
      rd_dvld_q <= 1'b0;
      rd_ovld_q <= 1'b0;
    end else begin
      if (list_clear) begin
        dvld_q <= '0;
      end else if (wr_en) begin
        dvld_q[wr_addr] <= 1'b1;
      end
      if (wr_en) begin
        ovld_q[wr_addr] <= 1'b1;
      end
      rd_dvld_q <= dvld_q[rd_addr];
      rd_ovld_q <= ovld_q[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rbls_pkg::S_IDLE;
      k_q          <= '0;
      beat_found_q <= 1'b0;
      beat_q       <= '0;
      ov_found_q   <= 1'b0;
      ov_q         <= LAST;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        rbls_pkg::S_IDLE: begin
          k_q          <= '0;
          beat_found_q <= 1'b0;
          ov_found_q   <= 1'b0;
          ov_q         <= LAST;
        end
        rbls_pkg::S_SC_EV: begin
          beat_found_q <= beat_found_d;
          beat_q       <= beat_d;
          ov_found_q   <= ov_found_d;
          ov_q         <= ov_d;
          // At the end of the scan the counter moves to the last slot to fill.
          k_q <= (k_q != LAST) ? AW'(k_q + 1'b1) : ov_d;
        end
        rbls_pkg::S_SH_WR: k_q <= AW'(k_q - 1'b1);
        default: ;
      endcase
      if (state_q == rbls_pkg::S_RESP && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Candidate, pending result and output word.
  always_ff @(posedge clk_i) begin
    case (state_q)
      rbls_pkg::S_IDLE: begin
        if (in_acc) begin
          cand_q       <= in_cand;
          si_q         <= in_slot_idx;
          res_q        <= '0;
          res_status_q <= (in_kind == rbls_pkg::KIND_OFFER) ? rbls_pkg::ST_BELOW
                                                            : rbls_pkg::ST_DONE;
          if (in_kind == rbls_pkg::KIND_READ) begin
            res_q.slot <= in_slot_idx;
          end
        end
      end
      rbls_pkg::S_SC_EV: begin
        if (k_q == LAST) begin
          res_status_q <= beat_found_d ? rbls_pkg::ST_OVERLAP_KEPT
                                       : rbls_pkg::ST_NOT_BETTER;
        end
      end
      rbls_pkg::S_INS: begin
        res_status_q <= rbls_pkg::ST_INSERTED;
        res_q.slot   <= IW'(beat_q);
      end
      rbls_pkg::S_RD_EV: begin
        res_q.x      <= ent_data.x;
        res_q.y      <= ent_data.y;
        res_q.z      <= ent_data.z;
        res_q.score  <= ent_data.score;
        res_q.orient <= ent_orient;
      end
      rbls_pkg::S_RESP: begin
        if (out_free) begin
          out_q        <= res_q;
          out_status_q <= res_status_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(rbls_pkg::OUT_TDATA_W - $bits(rbls_pkg::result_t))'(0), out_q};
  assign m_axis_tuser  = out_status_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // A shift only ever writes below the slot the candidate goes into.
  a_shift_below_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbls_pkg::S_SH_WR) |-> (k_q > beat_q))
    else $error("shift writes at or above the insert slot");

  // An insert always reports itself in the pending result.
  a_insert_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbls_pkg::S_INS) |=> (res_status_q == rbls_pkg::ST_INSERTED))
    else $error("insert not reported as inserted");

  // A shift pass is entered only with an overlap slot past the insert slot.
  a_shift_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbls_pkg::S_SC_EV && state_d == rbls_pkg::S_SH_RD) |=>
      (beat_found_q && (k_q > beat_q)))
    else $error("shift pass entered without a valid insert slot");

endmodule

`default_nettype wire

>>> dv/tb_ranked_box_list_overlap_suppress_unit.sv
`timescale 1ns / 1ps
// Testbench for ranked_box_list_overlap_suppress_unit: directed and random request words
// are checked against an in-bench model of the ranked box list, and registers are read back.
// Depends on rbls_pkg and the unit's RTL only.

module tb_ranked_box_list_overlap_suppress_unit;
  import rbls_pkg::*;

  localparam int unsigned LIST_DEPTH   = SLOTS_DEF;
  localparam int unsigned CLK_HALF     = 10;
  // Worst offer: full scan, every entry shifting, then the insert.
  localparam int unsigned QUIET_CYCLES = 2 + 4 * LIST_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PAY_W        = $bits(result_t);
  localparam int unsigned POS_MAX      = 1023;
  localparam int unsigned VOX_MAX      = 24'hFF_FFFF;

  // One request word, in input field order.
  typedef struct packed {
    kind_e                kind;
    logic [POS_W-1:0]     x;
    logic [POS_W-1:0]     y;
    logic [POS_W-1:0]     z;
    logic [ORIENT_W-1:0]  orient;
    logic [SCORE_W-1:0]   score;
    logic [VOX_W-1:0]     voxels;
    logic [IDX_W-1:0]     slot_index;
  } box_req_t;

  // One result word, in output field order.
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     slot;
    logic [POS_W-1:0]     x;
    logic [POS_W-1:0]     y;
    logic [POS_W-1:0]     z;
    logic [ORIENT_W-1:0]  orient;
    logic [SCORE_W-1:0]   score;
  } box_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // Fields from bit 0: pos_x, pos_y, pos_z, orient, score, voxel_count, slot_index, zero fill.
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // Fields from bit 0: kind.
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // Fields from bit 0: slot, entry_x, entry_y, entry_z, entry_orient, entry_score, zero fill.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // Fields from bit 0: status.
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]      pwdata;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  // Model copy of the list and of the registers.
  logic [POS_W-1:0]       list_x      [LIST_DEPTH];
  logic [POS_W-1:0]       list_y      [LIST_DEPTH];
  logic [POS_W-1:0]       list_z      [LIST_DEPTH];
  logic [ORIENT_W-1:0]    list_orient [LIST_DEPTH];
  logic [SCORE_W-1:0]     list_score  [LIST_DEPTH];
  logic [SIDE_W-1:0]      cfg_side_a;
  logic [SIDE_W-1:0]      cfg_side_b;
  logic [SIDE_W-1:0]      cfg_side_c;
  logic [VOX_W-1:0]       cfg_min_voxels;

  box_result_t            expected_results [$];
  bit                     gaps_on;
  int                     mismatches;
  int                     words_sent;
  int                     results_seen;
  int                     settings_used;
  int                     outcome_count [5];
  int                     cycle_count;

  ranked_box_list_overlap_suppress_unit #(
    .SLOTS (LIST_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Side lengths along x, y, z for an orientation; unused modes have no extent.
  function automatic void side_lengths(input logic [ORIENT_W-1:0] mode,
                                       output int sx, output int sy, output int sz);
    int a;
    int b;
    int c;
    a = cfg_side_a;
    b = cfg_side_b;
    c = cfg_side_c;
    sx = 0;
    sy = 0;
    sz = 0;
    case (mode)
      ORI_ABC: begin sx = a; sy = b; sz = c; end
      ORI_ACB: begin sx = a; sy = c; sz = b; end
      ORI_BAC: begin sx = b; sy = a; sz = c; end
      ORI_BCA: begin sx = b; sy = c; sz = a; end
      ORI_CAB: begin sx = c; sy = a; sz = b; end
      ORI_CBA: begin sx = c; sy = b; sz = a; end
      default: ;
    endcase
  endfunction

  // Two intervals on one axis meet when the gap between them is not positive.
  function automatic bit axis_meets(input int stored, input int cand,
                                    input int stored_len, input int cand_len);
    if (stored < cand) begin
      return (cand - stored) <= stored_len;
    end
    return (stored - cand) <= cand_len;
  endfunction

  // Applies one request word to the model list and returns the result it causes.
  function automatic box_result_t predict_outcome(input box_req_t req);
    box_result_t res;
    int beaten;
    int hit;
    int cx, cy, cz;
    int ex, ey, ez;
    res = '0;
    res.status = ST_DONE;
    case (req.kind)
      KIND_OFFER: begin
        if (req.voxels <= cfg_min_voxels) begin
          res.status = ST_BELOW;
        end else begin
          beaten = LIST_DEPTH;
          for (int k = LIST_DEPTH - 1; k >= 0; k--) begin
            if (req.score > list_score[k]) beaten = k;
          end
          if (beaten == LIST_DEPTH) begin
            res.status = ST_NOT_BETTER;
          end else begin
            // First overlapping entry among all but the last slot, empty ones included.
            side_lengths(req.orient, cx, cy, cz);
            hit = LIST_DEPTH - 1;
            for (int k = LIST_DEPTH - 2; k >= 0; k--) begin
              side_lengths(list_orient[k], ex, ey, ez);
              if (axis_meets(list_x[k], req.x, ex, cx) &&
                  axis_meets(list_y[k], req.y, ey, cy) &&
                  axis_meets(list_z[k], req.z, ez, cz)) hit = k;
            end
            if (hit < beaten) begin
              res.status = ST_OVERLAP_KEPT;
            end else begin
              for (int j = hit; j > beaten; j--) begin
                list_x[j]      = list_x[j-1];
                list_y[j]      = list_y[j-1];
                list_z[j]      = list_z[j-1];
                list_orient[j] = list_orient[j-1];
                list_score[j]  = list_score[j-1];
              end
              list_x[beaten]      = req.x;
              list_y[beaten]      = req.y;
              list_z[beaten]      = req.z;
              list_orient[beaten] = req.orient;
              list_score[beaten]  = req.score;
              res.status = ST_INSERTED;
              res.slot   = beaten[IDX_W-1:0];
            end
          end
        end
      end
      KIND_READ: begin
        res.slot = req.slot_index;
        if (req.slot_index < LIST_DEPTH) begin
          res.x      = list_x[req.slot_index];
          res.y      = list_y[req.slot_index];
          res.z      = list_z[req.slot_index];
          res.orient = list_orient[req.slot_index];
          res.score  = list_score[req.slot_index];
        end
      end
      KIND_CLEAR: begin
        // Orientations survive a clear.
        for (int k = 0; k < LIST_DEPTH; k++) begin
          list_x[k]     = '0;
          list_y[k]     = '0;
          list_z[k]     = '0;
          list_score[k] = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input int v);
    if (v < 0) return '0;
    if (v > POS_MAX) return POS_MAX[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  function automatic box_req_t make_word(input kind_e kind, input int x, input int y,
                                         input int z, input int orient,
                                         input logic [SCORE_W-1:0] score, input int voxels,
                                         input int slot_index);
    box_req_t w;
    w.kind       = kind;
    w.x          = x[POS_W-1:0];
    w.y          = y[POS_W-1:0];
    w.z          = z[POS_W-1:0];
    w.orient     = orient[ORIENT_W-1:0];
    w.score      = score;
    w.voxels     = voxels[VOX_W-1:0];
    w.slot_index = slot_index[IDX_W-1:0];
    return w;
  endfunction

  // Random word: mostly offers, some placed near a stored box and some scored near a stored score.
  function automatic box_req_t random_word();
    box_req_t w;
    int pick;
    int anchor;
    int spread;
    longint sc;
    longint vox;
    pick = $urandom_range(0, 99);
    if (pick < 3) w.kind = KIND_CLEAR;
    else if (pick < 5) w.kind = KIND_NOP;
    else if (pick < 20) w.kind = KIND_READ;
    else w.kind = KIND_OFFER;
    w.x          = $urandom_range(0, POS_MAX);
    w.y          = $urandom_range(0, POS_MAX);
    w.z          = $urandom_range(0, POS_MAX);
    w.orient     = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
    w.score      = $urandom();
    w.voxels     = $urandom_range(0, VOX_MAX);
    w.slot_index = $urandom_range(0, 7);
    if (w.kind == KIND_OFFER) begin
      anchor = $urandom_range(0, LIST_DEPTH - 1);
      spread = cfg_side_a;
      if (cfg_side_b > spread) spread = cfg_side_b;
      if (cfg_side_c > spread) spread = cfg_side_c;
      spread = spread + 2;
      if ($urandom_range(0, 1) == 1) begin
        w.x = clamp_pos(int'(list_x[anchor]) + int'($urandom_range(0, 2 * spread)) - spread);
        w.y = clamp_pos(int'(list_y[anchor]) + int'($urandom_range(0, 2 * spread)) - spread);
        w.z = clamp_pos(int'(list_z[anchor]) + int'($urandom_range(0, 2 * spread)) - spread);
      end
      case ($urandom_range(0, 3))
        0: ;
        1, 2: w.score = $urandom_range(1, 4000);
        default: begin
          sc = longint'(list_score[anchor]) + $urandom_range(0, 2);
          if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
          w.score = sc[SCORE_W-1:0];
        end
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        vox = longint'(cfg_min_voxels) + 1 + $urandom_range(0, 1000);
        if (vox > VOX_MAX) vox = VOX_MAX;
        w.voxels = vox[VOX_W-1:0];
      end else if (pick == 8) begin
        w.voxels = $urandom_range(0, cfg_min_voxels);
      end
    end
    return w;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < 10) $display("Mismatch: %s", what);
    mismatches++;
  endtask

  // Sends one request word and records its expected result once it is taken.
  task automatic send_word(input box_req_t req);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.kind;
    s_axis_tdata  <= {4'b0, req.slot_index, req.voxels, req.score, req.orient,
                      req.z, req.y, req.x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(predict_outcome(req));
    words_sent++;
    @(negedge clk_i);
  endtask

  // Holds the request side idle until every outstanding result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] mask;
    mask = (idx == REG_MIN_VOXELS) ? 32'h00FF_FFFF : 32'h0000_03FF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== (value & mask)) begin
      note_mismatch($sformatf("register %0d read back %h, expected %h",
                              idx, prdata, value & mask));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SIDE_A: cfg_side_a = value[SIDE_W-1:0];
      REG_SIDE_B: cfg_side_b = value[SIDE_W-1:0];
      REG_SIDE_C: cfg_side_c = value[SIDE_W-1:0];
      default:    cfg_min_voxels = value[VOX_W-1:0];
    endcase
  endtask

  // Reconfigures the box sides and threshold once the unit has gone idle.
  task automatic program_box_setup(input int a, input int b, input int c, input int min_vox);
    wait_for_results();
    repeat (QUIET_CYCLES) @(negedge clk_i);
    write_reg(REG_SIDE_A, a);
    write_reg(REG_SIDE_B, b);
    write_reg(REG_SIDE_C, c);
    write_reg(REG_MIN_VOXELS, min_vox);
    settings_used++;
  endtask

  // Reset contents: the first and last slots read empty, unused kind answers with nothing but done.
  task automatic test_reset_contents();
    send_word(make_word(KIND_READ, 0, 0, 0, 0, '0, 0, 0));
    send_word(make_word(KIND_READ, 0, 0, 0, 0, '0, 0, 7));
    send_word(make_word(KIND_NOP, 1023, 1023, 1023, 7, '1, VOX_MAX, 7));
  endtask

  // Voxel threshold boundary, a zero score, and the largest score at the far corner.
  task automatic test_threshold_and_ranking();
    program_box_setup(4, 6, 9, 10);
    send_word(make_word(KIND_OFFER, 3, 3, 3, 0, 32'd500, 10, 0));
    send_word(make_word(KIND_OFFER, 3, 3, 3, 0, 32'd0, 11, 0));
    send_word(make_word(KIND_OFFER, 1023, 1023, 1023, 0, 32'hFFFF_FFFF, VOX_MAX, 0));
  endtask

  // Overlap against empty slots, touching boxes, and zero-sized orientations.
  task automatic test_overlap_rules();
    send_word(make_word(KIND_OFFER, 0, 0, 0, 0, 32'd100, 11, 0));
    send_word(make_word(KIND_OFFER, 1019, 1023, 1023, 0, 32'd50, 11, 0));
    send_word(make_word(KIND_OFFER, 1018, 1023, 1023, 0, 32'd50, 11, 0));
    send_word(make_word(KIND_OFFER, 0, 0, 0, 6, 32'd200, 11, 0));
    send_word(make_word(KIND_OFFER, 5, 5, 5, 7, 32'd1, 11, 0));
  endtask

  // Every slot read back, then a clear that keeps orientations.
  task automatic test_read_and_clear();
    for (int k = 0; k < 8; k++) begin
      send_word(make_word(KIND_READ, 0, 0, 0, 0, '0, 0, k));
    end
    send_word(make_word(KIND_CLEAR, 7, 7, 7, 2, 32'd9, 99, 3));
    send_word(make_word(KIND_READ, 0, 0, 0, 0, '0, 0, 1));
    send_word(make_word(KIND_READ, 0, 0, 0, 0, '0, 0, 3));
    send_word(make_word(KIND_OFFER, 0, 0, 0, 0, 32'd1, 11, 0));
  endtask

  // Random traffic under one register setting.
  task automatic test_random_traffic(input int a, input int b, input int c, input int min_vox,
                                     input int count, input bit with_gaps);
    program_box_setup(a, b, c, min_vox);
    gaps_on = with_gaps;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) wait_for_results();
      send_word(random_word());
    end
  endtask

  // Result consumer with random stall bursts.
  initial begin : result_sink
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compares each accepted result word against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    box_result_t want;
    box_result_t got;
    result_t     pay;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      pay        = result_t'(m_axis_tdata[PAY_W-1:0]);
      got.status = m_axis_tuser;
      got.slot   = pay.slot;
      got.x      = pay.x;
      got.y      = pay.y;
      got.z      = pay.z;
      got.orient = pay.orient;
      got.score  = pay.score;
      results_seen++;
      if (got.status < 5) outcome_count[got.status]++;
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: status %0d slot %0d",
                                got.status, got.slot));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.orient !== want.orient || got.score !== want.score ||
            m_axis_tdata[OUT_TDATA_W-1:PAY_W] !== '0) begin
          note_mismatch($sformatf({"result %0d expected status %0d slot %0d x %0d y %0d ",
                                   "z %0d orient %0d score %h, got status %0d slot %0d ",
                                   "x %0d y %0d z %0d orient %0d score %h fill %h"},
                                  results_seen, want.status, want.slot, want.x, want.y,
                                  want.z, want.orient, want.score, got.status, got.slot,
                                  got.x, got.y, got.z, got.orient, got.score,
                                  m_axis_tdata[OUT_TDATA_W-1:PAY_W]));
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycle_count, expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  // Test sequence.
  initial begin : test_sequence
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gaps_on       = 1'b1;
    mismatches    = 0;
    words_sent    = 0;
    results_seen  = 0;
    settings_used = 1;
    for (int k = 0; k < 5; k++) outcome_count[k] = 0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      list_x[k]      = '0;
      list_y[k]      = '0;
      list_z[k]      = '0;
      list_orient[k] = '0;
      list_score[k]  = '0;
    end
    cfg_side_a     = 1;
    cfg_side_b     = 1;
    cfg_side_c     = 1;
    cfg_min_voxels = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_contents();
    test_threshold_and_ranking();
    test_overlap_rules();
    test_read_and_clear();
    test_random_traffic(5, 9, 13, 100, 200, 1'b1);
    test_random_traffic(1023, 1023, 1023, 0, 120, 1'b1);
    test_random_traffic(1, 1, 1, VOX_MAX, 30, 1'b0);
    test_random_traffic(1, 2, 3, 0, 200, 1'b1);
    test_random_traffic($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                        $urandom_range(0, 5000), 200, 1'b1);
    // Closing stretch runs without random gaps on either side.
    test_random_traffic(20, 40, 80, 50, 150, 1'b0);

    wait_for_results();
    repeat (QUIET_CYCLES) @(negedge clk_i);

    $display("Sent %0d request words over %0d register settings; %0d results checked.",
             words_sent, settings_used, results_seen);
    $display("Outcomes: %0d below threshold, %0d not better, %0d overlap drops, %0d inserts, %0d reads/clears.",
             outcome_count[ST_BELOW], outcome_count[ST_NOT_BETTER],
             outcome_count[ST_OVERLAP_KEPT], outcome_count[ST_INSERTED], outcome_count[ST_DONE]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
